// ----- rtl/qsr_pkg.sv -----
package qsr_pkg;

  localparam int XW = 13;
  localparam int YW = 6;
  localparam int COLOR_W = 24;
  localparam int RCW = 7;

  localparam logic [RCW-1:0] ROW_COUNT_RST = 7'd64;

  // corner codes
  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;
  localparam logic [1:0] CORNER_D = 2'd3;

  // edge codes, in walk order
  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_CD = 2'd1;
  localparam logic [1:0] EDGE_AC = 2'd2;
  localparam logic [1:0] EDGE_BD = 2'd3;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } point_t;

  typedef struct packed {
    logic          valid;
    logic [YW-1:0] row;
    logic [XW-1:0] x;
  } pix_t;

  typedef struct packed {
    logic clear;
    logic scan_start;
  } tbl_ctrl_t;

  function automatic logic [1:0] edge_start(input logic [1:0] edge_code);
    logic [1:0] c;
    case (edge_code)
      EDGE_AB: c = CORNER_A;
      EDGE_CD: c = CORNER_C;
      EDGE_AC: c = CORNER_A;
      EDGE_BD: c = CORNER_B;
      default: c = CORNER_A;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] edge_end(input logic [1:0] edge_code);
    logic [1:0] c;
    case (edge_code)
      EDGE_AB: c = CORNER_B;
      EDGE_CD: c = CORNER_D;
      EDGE_AC: c = CORNER_C;
      EDGE_BD: c = CORNER_D;
      default: c = CORNER_B;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/qsr_walker.sv -----
module qsr_walker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  qsr_pkg::point_t [3:0]              corners_i,
  input  logic [qsr_pkg::RCW-1:0]            lim_i,
  output qsr_pkg::pix_t                      pix_o,
  output logic                               busy_o
);

  typedef enum logic [3:0] {
    W_IDLE = 4'b0001,
    W_LOAD = 4'b0010,
    W_PREP = 4'b0100,
    W_STEP = 4'b1000
  } wstate_e;

  wstate_e state_q, state_d;

  qsr_pkg::point_t [3:0]       corner_q, corner_d;
  logic [1:0]                  edge_q, edge_d;
  logic [qsr_pkg::XW-1:0]      cur_x_q, cur_x_d, end_x_q, end_x_d, dx_q, dx_d;
  logic [qsr_pkg::YW-1:0]      cur_y_q, cur_y_d, end_y_q, end_y_d, dy_q, dy_d;
  logic                        sxn_q, sxn_d, syn_q, syn_d, xmaj_q, xmaj_d;
  logic [15:0]                 err_q, err_d, inc_a_q, inc_a_d, inc_b_q, inc_b_d;
  qsr_pkg::pix_t               pix_q, pix_d;

  qsr_pkg::point_t             p_start, p_end;
  logic                        x_lt, y_lt;
  logic [15:0]                 dx2, dy2;
  logic                        step_x, step_y, done;
  logic [qsr_pkg::XW-1:0]      nx;
  logic [qsr_pkg::YW-1:0]      ny;

  always_comb begin
    p_start = corner_q[qsr_pkg::edge_start(edge_q)];
    p_end   = corner_q[qsr_pkg::edge_end(edge_q)];
    x_lt    = p_start.x < p_end.x;
    y_lt    = p_start.y < p_end.y;
    dx2     = {2'b00, dx_q, 1'b0};
    dy2     = {9'd0, dy_q, 1'b0};
    // err sign bit clear means the minor axis steps too
    step_x  = xmaj_q | ~err_q[15];
    step_y  = ~xmaj_q | ~err_q[15];
    done    = xmaj_q ? (cur_x_q == end_x_q) : (cur_y_q == end_y_q);
    nx      = step_x ? (sxn_q ? cur_x_q - 13'd1 : cur_x_q + 13'd1) : cur_x_q;
    ny      = step_y ? (syn_q ? cur_y_q - 6'd1 : cur_y_q + 6'd1) : cur_y_q;

    state_d   = state_q;
    corner_d  = corner_q;
    edge_d    = edge_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    end_x_d   = end_x_q;
    end_y_d   = end_y_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    sxn_d     = sxn_q;
    syn_d     = syn_q;
    xmaj_d    = xmaj_q;
    err_d     = err_q;
    inc_a_d   = inc_a_q;
    inc_b_d   = inc_b_q;
    pix_d     = pix_q;
    pix_d.valid = 1'b0;

    case (state_q)
      W_IDLE: begin
        if (start_i) begin
          corner_d = corners_i;
          edge_d   = qsr_pkg::EDGE_AB;
          state_d  = W_LOAD;
        end
      end
      W_LOAD: begin
        cur_x_d = p_start.x;
        cur_y_d = p_start.y;
        end_x_d = p_end.x;
        end_y_d = p_end.y;
        sxn_d   = ~x_lt;
        syn_d   = ~y_lt;
        dx_d    = x_lt ? p_end.x - p_start.x : p_start.x - p_end.x;
        dy_d    = y_lt ? p_end.y - p_start.y : p_start.y - p_end.y;
        // start pixel of the edge
        pix_d.valid = ({1'b0, p_start.y} < lim_i);
        pix_d.row   = p_start.y;
        pix_d.x     = p_start.x;
        state_d = W_PREP;
      end
      W_PREP: begin
        xmaj_d = dx_q > {7'd0, dy_q};
        if (dx_q > {7'd0, dy_q}) begin
          err_d   = dy2 - {3'd0, dx_q};
          inc_a_d = dy2;
          inc_b_d = dy2 - dx2;
        end else begin
          err_d   = dx2 - {10'd0, dy_q};
          inc_a_d = dx2;
          inc_b_d = dx2 - dy2;
        end
        state_d = W_STEP;
      end
      W_STEP: begin
        if (done) begin
          if (edge_q == qsr_pkg::EDGE_BD) begin
            state_d = W_IDLE;
          end else begin
            edge_d  = edge_q + 2'd1;
            state_d = W_LOAD;
          end
        end else begin
          cur_x_d = nx;
          cur_y_d = ny;
          err_d   = err_q[15] ? err_q + inc_a_q : err_q + inc_b_q;
          pix_d.valid = ({1'b0, ny} < lim_i);
          pix_d.row   = ny;
          pix_d.x     = nx;
        end
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      pix_q   <= '0;
    end else begin
      state_q <= state_d;
      pix_q   <= pix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    corner_q <= corner_d;
    edge_q   <= edge_d;
    cur_x_q  <= cur_x_d;
    cur_y_q  <= cur_y_d;
    end_x_q  <= end_x_d;
    end_y_q  <= end_y_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    sxn_q    <= sxn_d;
    syn_q    <= syn_d;
    xmaj_q   <= xmaj_d;
    err_q    <= err_d;
    inc_a_q  <= inc_a_d;
    inc_b_q  <= inc_b_d;
  end

  assign pix_o  = pix_q;
  assign busy_o = (state_q != W_IDLE) | pix_q.valid;

`ifndef SYNTH
  a_pix_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_q.valid |-> ({1'b0, pix_q.row} < lim_i))
    else $error("clipped pixel passed to span table");
`endif

endmodule

// ----- rtl/qsr_span_table.sv -----
module qsr_span_table #(
  parameter int ROWS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qsr_pkg::tbl_ctrl_t            ctrl_i,
  input  qsr_pkg::pix_t                 pix_i,
  input  logic [qsr_pkg::COLOR_W-1:0]   color_i,
  output logic                          busy_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [55:0]                   m_axis_tdata,
  output logic                          m_axis_tlast
);

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = $clog2(ROWS + 1);

  typedef struct packed {
    logic [qsr_pkg::XW-1:0] right;
    logic [qsr_pkg::XW-1:0] left;
  } entry_t;

  entry_t                  mem_q [ROWS];
  entry_t                  rdata_q;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;

  qsr_pkg::pix_t           p1_q;
  logic [AW-1:0]           p1_row;
  logic                    wr_valid_q;
  logic [AW-1:0]           wr_row_q;
  entry_t                  wr_data_q;
  entry_t                  base, merged;

  logic [ROWS-1:0]         touched_q, above;
  logic                    scan_active_q;
  logic [CW-1:0]           scan_q;
  logic                    scan_end, scan_hit, scan_last, issue, e1_take;

  logic                    e1_valid_q, e1_last_q;
  logic [AW-1:0]           e1_row_q;

  logic                    out_valid_q, out_last_q, out_free;
  logic [55:0]             out_data_q;

  // read-modify-write of one row, forwarding the write of the previous cycle
  always_comb begin
    p1_row = p1_q.row[AW-1:0];
    base   = (wr_valid_q && (wr_row_q == p1_row)) ? wr_data_q : rdata_q;
    if (touched_q[p1_row]) begin
      merged.left  = (p1_q.x < base.left) ? p1_q.x : base.left;
      merged.right = (p1_q.x > base.right) ? p1_q.x : base.right;
    end else begin
      merged.left  = p1_q.x;
      merged.right = p1_q.x;
    end
  end

  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      above[i] = CW'(i) > scan_q;
    end
    scan_end  = (scan_q == CW'(ROWS));
    scan_hit  = !scan_end && touched_q[scan_q[AW-1:0]];
    scan_last = ~|(touched_q & above);
    out_free  = !out_valid_q || m_axis_tready;
    e1_take   = !e1_valid_q || out_free;
    issue     = scan_active_q && scan_hit && e1_take;
    rd_en     = issue || pix_i.valid;
    rd_addr   = scan_active_q ? scan_q[AW-1:0] : pix_i.row[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (p1_q.valid) begin
      mem_q[p1_row] <= merged;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q          <= '0;
      wr_valid_q    <= 1'b0;
      touched_q     <= '0;
      scan_active_q <= 1'b0;
      scan_q        <= '0;
      e1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      p1_q       <= pix_i;
      wr_valid_q <= p1_q.valid;
      if (ctrl_i.clear) begin
        touched_q <= '0;
      end else if (p1_q.valid) begin
        touched_q[p1_row] <= 1'b1;
      end
      if (ctrl_i.scan_start) begin
        scan_active_q <= 1'b1;
        scan_q        <= '0;
      end else if (scan_active_q) begin
        if (scan_end) begin
          scan_active_q <= 1'b0;
        end else if (!scan_hit || e1_take) begin
          scan_q <= scan_q + CW'(1);
        end
      end
      if (e1_take) begin
        e1_valid_q <= issue;
      end
      if (out_free) begin
        out_valid_q <= e1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_row_q  <= p1_row;
    wr_data_q <= merged;
    if (issue) begin
      e1_row_q  <= scan_q[AW-1:0];
      e1_last_q <= scan_last;
    end
    if (out_free && e1_valid_q) begin
      out_data_q <= {color_i, rdata_q.right, rdata_q.left, qsr_pkg::YW'(e1_row_q)};
      out_last_q <= e1_last_q;
    end
  end

  assign busy_o        = p1_q.valid | scan_active_q | e1_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
  a_written_row_touched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_q |-> touched_q[wr_row_q])
    else $error("row written without its touched bit");

  a_walk_scan_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e1_valid_q || scan_active_q) |-> !p1_q.valid)
    else $error("edge walk overlaps span readout");
`endif

endmodule

// ----- rtl/quad_span_rasterizer.sv -----
// quad span rasterizer
//
// input stream: one quad per transfer (four corners and a fill color).
// edges a-b, c-d, a-c and b-d are walked one pixel per cycle; each pixel
// widens the least/greatest x of its row in a row table memory
// (read-modify-write with forwarding of the previous write).
// output stream: one span per touched row, rows in increasing order,
// tlast on the final span of the quad. a quad that touches no row
// (all pixels clipped) produces no transfer.
// config: cfg_we_i writes row_count; rows at or above min(row_count, ROWS)
// are clipped. write it only while the block is idle.
// sequence: each edge is loaded and set up, then walked to its end along its
// longer axis; then the table write stage drains and the rows are scanned, at
// most one table read per cycle, paused while the output stalls.
// s_axis_tready is high only between quads; the last span may still wait in
// the output register while the next quad is taken.
// reset: row_count returns to 64, all pipelines empty, no span pending.
// receiver stall: the output register holds its span and the row scan
// waits; nothing is dropped.
module quad_span_rasterizer #(
  parameter int ROWS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // row_count register write
  input  logic                    cfg_we_i,
  input  logic [6:0]              cfg_wdata_i,
  // quad input
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // fields from bit 0: corner_a_x, corner_a_y, corner_b_x, corner_b_y,
  // corner_c_x, corner_c_y, corner_d_x, corner_d_y, fill_color, zero pad
  input  logic [103:0]            s_axis_tdata,
  // span output
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // fields from bit 0: span_row, span_left, span_right, span_color
  output logic [55:0]             m_axis_tdata,
  // last_span
  output logic                    m_axis_tlast
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_WALK = 3'b010,
    T_EMIT = 3'b100
  } tstate_e;

  tstate_e state_q, state_d;

  logic [qsr_pkg::RCW-1:0]      row_count_q, lim;
  logic [qsr_pkg::COLOR_W-1:0]  color_q;
  qsr_pkg::point_t [3:0]        corners;
  qsr_pkg::pix_t                pix;
  qsr_pkg::tbl_ctrl_t           tbl_ctrl;
  logic                         accept, walk_busy, tbl_busy, walk_done;

  // unpack corners from the input transfer
  always_comb begin
    corners[qsr_pkg::CORNER_A].x = s_axis_tdata[12:0];
    corners[qsr_pkg::CORNER_A].y = s_axis_tdata[18:13];
    corners[qsr_pkg::CORNER_B].x = s_axis_tdata[31:19];
    corners[qsr_pkg::CORNER_B].y = s_axis_tdata[37:32];
    corners[qsr_pkg::CORNER_C].x = s_axis_tdata[50:38];
    corners[qsr_pkg::CORNER_C].y = s_axis_tdata[56:51];
    corners[qsr_pkg::CORNER_D].x = s_axis_tdata[69:57];
    corners[qsr_pkg::CORNER_D].y = s_axis_tdata[75:70];
  end

  // effective row limit, capped to the table depth
  assign lim = (row_count_q > qsr_pkg::RCW'(ROWS)) ? qsr_pkg::RCW'(ROWS) : row_count_q;

  assign s_axis_tready = (state_q == T_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  // walk finished once walker and table write stage have drained
  assign walk_done     = !walk_busy && !tbl_busy;

  always_comb begin
    state_d             = state_q;
    tbl_ctrl.clear      = accept;
    tbl_ctrl.scan_start = 1'b0;
    case (state_q)
      T_IDLE: begin
        if (accept) begin
          state_d = T_WALK;
        end
      end
      T_WALK: begin
        if (walk_done) begin
          tbl_ctrl.scan_start = 1'b1;
          state_d             = T_EMIT;
        end
      end
      T_EMIT: begin
        if (!tbl_busy) begin
          state_d = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      row_count_q <= qsr_pkg::ROW_COUNT_RST;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        row_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      color_q <= s_axis_tdata[99:76];
    end
  end

  qsr_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .corners_i (corners),
    .lim_i     (lim),
    .pix_o     (pix),
    .busy_o    (walk_busy)
  );

  qsr_span_table #(
    .ROWS (ROWS)
  ) u_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (tbl_ctrl),
    .pix_i         (pix),
    .color_i       (color_q),
    .busy_o        (tbl_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTH
  a_idle_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_IDLE) |-> (!walk_busy && !tbl_busy))
    else $error("quad accepted while previous one still in flight");

  a_accept_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> walk_busy)
    else $error("edge walker did not start after quad transfer");
`endif

endmodule

// ----- test/tb.sv -----
module tb;

  localparam int ROWS = 64;
  localparam int QUAD_W = 4 * (qsr_pkg::XW + qsr_pkg::YW) + qsr_pkg::COLOR_W;  // 100 bits
  localparam logic [qsr_pkg::XW-1:0] EMPTY_LEFT = '1;  // 8191, left edge before any pixel

  // one quad as it sits in s_axis_tdata, first field (corner_a_x) in the lowest bits
  typedef struct packed {
    logic [qsr_pkg::COLOR_W-1:0] color;
    logic [qsr_pkg::YW-1:0]      d_y;
    logic [qsr_pkg::XW-1:0]      d_x;
    logic [qsr_pkg::YW-1:0]      c_y;
    logic [qsr_pkg::XW-1:0]      c_x;
    logic [qsr_pkg::YW-1:0]      b_y;
    logic [qsr_pkg::XW-1:0]      b_x;
    logic [qsr_pkg::YW-1:0]      a_y;
    logic [qsr_pkg::XW-1:0]      a_x;
  } quad_t;

  // one span we expect on the output stream
  typedef struct {
    logic [qsr_pkg::YW-1:0]      row;
    logic [qsr_pkg::XW-1:0]      left;
    logic [qsr_pkg::XW-1:0]      right;
    logic [qsr_pkg::COLOR_W-1:0] color;
    logic                        last;
  } span_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [6:0]   cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [55:0]  m_axis_tdata;
  logic         m_axis_tlast;

  quad_span_rasterizer #(
    .ROWS(ROWS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // quads waiting to be offered, spans waiting to be seen
  quad_t quad_q[$];
  span_t span_q[$];

  // shadow of the row table and of the row_count register
  logic [qsr_pkg::XW-1:0] row_lo[ROWS];
  logic [qsr_pkg::XW-1:0] row_hi[ROWS];
  logic                   row_hit[ROWS];
  int                     rows_in_use = ROWS;

  int  errors = 0;
  int  last_quad_cost = 200;  // rough cycle count of the most recent quad
  int  wide_left = 8;         // budget of full-width quads in the random part
  bit  calm = 1'b0;           // no random idling on either side while set
  bit  hold_asked = 1'b0;     // ask the receiver for one long hold-off
  bit  hold_spent = 1'b0;
  int  hold_left = 0;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // widen the span of row y by pixel x, rows past the clip line are dropped
  function automatic void widen_row(int x, int y);
    logic [qsr_pkg::XW-1:0] xv;
    if (y < 0 || y >= rows_in_use) return;
    xv = x[qsr_pkg::XW-1:0];
    if (!row_hit[y]) begin
      row_hit[y] = 1'b1;
      row_lo[y] = xv;
      row_hi[y] = xv;
    end else begin
      if (xv < row_lo[y]) row_lo[y] = xv;
      if (xv > row_hi[y]) row_hi[y] = xv;
    end
  endfunction

  // bresenham walk from (x1,y1) to (x2,y2), start pixel included;
  // returns the number of steps taken
  function automatic int walk_edge(int x1, int y1, int x2, int y2);
    int x, y, sx, sy, ddx, ddy, err;
    x = x1;
    y = y1;
    sx = (x1 < x2) ? 1 : -1;
    sy = (y1 < y2) ? 1 : -1;
    ddx = (x1 < x2) ? x2 - x1 : x1 - x2;
    ddy = (y1 < y2) ? y2 - y1 : y1 - y2;
    widen_row(x, y);
    if (ddx > ddy) begin
      // shallow: one x step per pixel
      err = 2 * ddy - ddx;
      while (x != x2) begin
        if (err >= 0) begin
          y += sy;
          err += 2 * (ddy - ddx);
        end else begin
          err += 2 * ddy;
        end
        x += sx;
        widen_row(x, y);
      end
    end else begin
      // steep or single point: one y step per pixel
      err = 2 * ddx - ddy;
      while (y != y2) begin
        if (err >= 0) begin
          x += sx;
          err += 2 * (ddx - ddy);
        end else begin
          err += 2 * ddx;
        end
        y += sy;
        widen_row(x, y);
      end
    end
    return (ddx > ddy) ? ddx : ddy;
  endfunction

  // scan-convert one quad and queue its spans, last one flagged
  function automatic void rasterize_quad(quad_t q);
    int    steps;
    int    n0;
    span_t s;
    for (int r = 0; r < ROWS; r++) begin
      row_lo[r] = EMPTY_LEFT;
      row_hi[r] = '0;
      row_hit[r] = 1'b0;
    end
    steps = walk_edge(q.a_x, q.a_y, q.b_x, q.b_y);
    steps += walk_edge(q.c_x, q.c_y, q.d_x, q.d_y);
    steps += walk_edge(q.a_x, q.a_y, q.c_x, q.c_y);
    steps += walk_edge(q.b_x, q.b_y, q.d_x, q.d_y);
    last_quad_cost = 20 + ROWS + steps;
    n0 = span_q.size();
    for (int r = 0; r < ROWS; r++) begin
      if (row_hit[r]) begin
        s.row = r[qsr_pkg::YW-1:0];
        s.left = row_lo[r];
        s.right = row_hi[r];
        s.color = q.color;
        s.last = 1'b0;
        span_q.push_back(s);
      end
    end
    if (span_q.size() > n0) span_q[$].last = 1'b1;
  endfunction

  function automatic quad_t make_quad(int ax, int ay, int bx, int by, int cx, int cy,
                                      int dx, int dy, int color);
    quad_t q;
    q.a_x = ax[qsr_pkg::XW-1:0];
    q.a_y = ay[qsr_pkg::YW-1:0];
    q.b_x = bx[qsr_pkg::XW-1:0];
    q.b_y = by[qsr_pkg::YW-1:0];
    q.c_x = cx[qsr_pkg::XW-1:0];
    q.c_y = cy[qsr_pkg::YW-1:0];
    q.d_x = dx[qsr_pkg::XW-1:0];
    q.d_y = dy[qsr_pkg::YW-1:0];
    q.color = color[qsr_pkg::COLOR_W-1:0];
    return q;
  endfunction

  // mostly narrow quads placed anywhere in x, a few spanning the full width
  function automatic quad_t random_quad();
    int    base, reach;
    quad_t q;
    if (wide_left > 0 && $urandom_range(19) == 0) begin
      wide_left--;
      base = 0;
      reach = 8191;
    end else begin
      reach = $urandom_range(1, 48);
      base = $urandom_range(0, 8191 - reach);
    end
    q = make_quad(base + $urandom_range(0, reach), $urandom_range(0, 63),
                  base + $urandom_range(0, reach), $urandom_range(0, 63),
                  base + $urandom_range(0, reach), $urandom_range(0, 63),
                  base + $urandom_range(0, reach), $urandom_range(0, 63),
                  $urandom_range(0, 24'hFFFFFF));
    // now and then collapse an edge to a single point
    if ($urandom_range(7) == 0) begin
      q.b_x = q.a_x;
      q.b_y = q.a_y;
    end
    return q;
  endfunction

  task automatic feed(input int n);
    repeat (n) quad_q.push_back(random_quad());
  endtask

  // wait until the sender is empty and every span has come, then give the
  // block time to finish a quad that may produce nothing
  task automatic drain;
    do @(negedge clk_i);
    while (quad_q.size() != 0 || s_axis_tvalid || span_q.size() != 0);
    repeat (last_quad_cost + 100) @(negedge clk_i);
  endtask

  task automatic set_row_count(input int v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[6:0];
    rows_in_use = (v > ROWS) ? ROWS : v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // sender: next quad goes out once the current transfer is done
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (quad_q.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, quad_q.pop_front()};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure plus one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked && !hold_spent) begin
      m_axis_tready <= 1'b0;
      hold_left <= 800;
      hold_spent <= 1'b1;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 38);
    end
  end

  // monitor: check output transfers, predict on input transfers
  always @(posedge clk_i) begin
    span_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (span_q.size() == 0) begin
          flag_mismatch("span with nothing pending, row", m_axis_tdata[5:0], 0);
        end else begin
          want = span_q.pop_front();
          if (m_axis_tdata[5:0] !== want.row)
            flag_mismatch("span_row", m_axis_tdata[5:0], want.row);
          if (m_axis_tdata[18:6] !== want.left)
            flag_mismatch("span_left", m_axis_tdata[18:6], want.left);
          if (m_axis_tdata[31:19] !== want.right)
            flag_mismatch("span_right", m_axis_tdata[31:19], want.right);
          if (m_axis_tdata[55:32] !== want.color)
            flag_mismatch("span_color", m_axis_tdata[55:32], want.color);
          if (m_axis_tlast !== want.last)
            flag_mismatch("last_span", m_axis_tlast, want.last);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        rasterize_quad(quad_t'(s_axis_tdata[QUAD_W-1:0]));
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed quads at the full row count
    set_row_count(ROWS);
    // everything on the origin: one pixel, right edge at x = 0
    quad_q.push_back(make_quad(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // everything on the far corner
    quad_q.push_back(make_quad(8190, 63, 8190, 63, 8190, 63, 8190, 63, 24'hFFFFFF));
    // full-screen rectangle
    quad_q.push_back(make_quad(0, 0, 8190, 0, 0, 63, 8190, 63, 24'h123456));
    // x of 8191, the largest value the x field holds
    quad_q.push_back(make_quad(8191, 10, 8191, 10, 8191, 20, 8191, 20, 24'h5A5A5A));
    // edges a-b and c-d degenerate, edges a-c and b-d horizontal
    quad_q.push_back(make_quad(100, 5, 100, 5, 110, 5, 110, 5, 24'hA5A5A5));
    // diamond, edges going up and down
    quad_q.push_back(make_quad(40, 0, 80, 30, 0, 30, 40, 63, 24'h00FF00));
    // steep sliver
    quad_q.push_back(make_quad(10, 0, 12, 63, 10, 0, 12, 63, 24'hFF0000));
    // shallow edges walked right to left, in both row directions
    quad_q.push_back(make_quad(8000, 50, 7000, 40, 7900, 60, 6900, 45, 24'h0000FF));
    // vertical strip on x = 0
    quad_q.push_back(make_quad(0, 10, 0, 20, 0, 10, 0, 20, 24'h800001));
    // self-crossing bow tie
    quad_q.push_back(make_quad(0, 0, 60, 60, 60, 0, 0, 60, 24'h7FFFFE));
    // full-width quad walked backward
    quad_q.push_back(make_quad(8190, 63, 0, 0, 8190, 0, 0, 63, 24'h010203));
    // alternating bit patterns in every field
    quad_q.push_back(make_quad(13'h1555, 6'h2A, 13'h0AAA, 6'h15, 13'h1555, 6'h15,
                               13'h0AAA, 6'h2A, 24'hAAAAAA));
    // one row only
    quad_q.push_back(make_quad(5, 33, 9, 33, 3, 33, 20, 33, 24'h555555));
    // corners at rows 62, 63, 0 and 1, so edges run the full table height
    quad_q.push_back(make_quad(4095, 62, 4096, 63, 4094, 0, 4097, 1, 24'hC3C3C3));

    // random, with a pause until every span is in halfway through
    feed(18);
    drain();
    feed(18);
    drain();

    // only row 0 survives
    set_row_count(1);
    feed(12);
    drain();

    // everything clipped, no spans at all
    set_row_count(0);
    feed(10);
    drain();

    // row count above the table, sender pushing while the receiver holds off
    set_row_count(127);
    calm = 1'b1;
    hold_asked = 1'b1;
    feed(14);
    drain();
    calm = 1'b0;

    set_row_count($urandom_range(2, 63));
    feed(28);
    drain();

    // back to the full table: a stretch with no idling, then idling again
    set_row_count(ROWS);
    calm = 1'b1;
    feed(20);
    drain();
    calm = 1'b0;
    feed(12);
    drain();

    if (errors == 0)
      $display("quad_span_rasterizer verification clean");
    else
      $display("quad_span_rasterizer verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("quad_span_rasterizer verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/qsr_pkg.sv
rtl/qsr_walker.sv
rtl/qsr_span_table.sv
rtl/quad_span_rasterizer.sv
test/tb.sv
